### rtl/ordered_key_value_table_unit_macros.svh
// Assertion macros for the ordered key/value table unit
`ifndef ORDERED_KEY_VALUE_TABLE_UNIT_MACROS_SVH
`define ORDERED_KEY_VALUE_TABLE_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define OKVT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OKVT_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define OKVT_ASSERT(lbl, clk, rst_n, prop, msg)
`define OKVT_ASSERT_NORST(lbl, clk, prop, msg)
`endif

`endif

### rtl/okvt_pkg.sv
// Types and constants shared by the ordered key/value table unit
`default_nettype none

package okvt_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_BITS  = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int POS_BITS   = 6;
    localparam int IN_BITS    = 80;
    localparam int OUT_BITS   = 80;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_ERASE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RDOUT
    } state_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic [KEY_BITS-1:0]   key;
    } entry_t;

    typedef struct packed {
        logic                 wr_en;
        logic [ADDR_BITS-1:0] wr_addr;
        entry_t               wr_data;
        logic                 rd_en;
        logic [ADDR_BITS-1:0] rd_addr;
    } store_req_t;

endpackage

`default_nettype wire

### rtl/okvt_store.sv
// Entry store: one synchronous memory of key/value pairs, registered read
`default_nettype none

module okvt_store (
    input  wire                       aclk,
    input  wire okvt_pkg::store_req_t req,
    output okvt_pkg::entry_t          rd_data
);
    import okvt_pkg::*;

    entry_t store_mem [CAPACITY];
    entry_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            store_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= store_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/ordered_key_value_table_unit.sv
// Ordered key/value table: top level with sequencer, entry store and result register
//
// channel  dir  tdata fields (lsb first)
// s_axis   in   op[1:0] key[33:2] write_value[65:34] may_insert[66] may_update[67]
//               position[73:68]
// m_axis   out  ok[0] full_res[1] key_out[33:2] value_out[65:34] found_position[71:66]
//               entry_count[78:72]
//
// Write, erase, lookup: an accept, then a linear scan of the entries on the store read port.
// A key match at index w ends the scan there.
// Erase of entry at index w adds read/write-back compaction of the entries above w.
// Read at position: one store read. Next transaction is taken once the result is in m_axis.
// Reset clears state, count, flags; store contents undefined until written, no clearing pass.
// A stalled m_axis holds the block in its final cycle until the result register frees.
`default_nettype none

module ordered_key_value_table_unit (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    // op, key, write_value, may_insert, may_update, position, zero pad
    input  wire  [okvt_pkg::IN_BITS-1:0] s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    // ok, full_res, key_out, value_out, found_position, entry_count, zero pad
    output logic [okvt_pkg::OUT_BITS-1:0] m_axis_tdata
);
    import okvt_pkg::*;

    `include "ordered_key_value_table_unit_macros.svh"

    state_t                state_reg, state_next;
    logic [CNT_BITS-1:0]   count_reg, count_next;
    logic [CNT_BITS-1:0]   idx_reg, idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [ADDR_BITS-1:0]  cmp_idx_reg, cmp_idx_next;

    op_t                   op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic                  ins_reg;
    logic                  upd_reg;
    logic [POS_BITS-1:0]   pos_reg;

    logic                  ov_reg, ov_next;
    logic                  ok_reg, ok_next;
    logic                  full_reg, full_next;
    logic [KEY_BITS-1:0]   kout_reg, kout_next;
    logic [VALUE_BITS-1:0] vout_reg, vout_next;
    logic [ADDR_BITS-1:0]  fpos_reg, fpos_next;
    logic [CNT_BITS-1:0]   ocnt_reg, ocnt_next;

    op_t                   in_op;
    logic [POS_BITS-1:0]   in_pos;
    logic                  accept;
    logic                  out_free;
    logic                  hit;
    logic                  pos_ok;
    store_req_t            req;
    entry_t                rd_data;

    logic                  count_step_ok;
    logic                  count_grow_ok;
    logic                  shift_wr_ok;

    assign in_op    = op_t'(s_axis_tdata[1:0]);
    assign in_pos   = s_axis_tdata[73:68];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign out_free = !ov_reg || m_axis_tready;
    assign hit      = cmp_valid_reg && (rd_data.key == key_reg);
    assign pos_ok   = CNT_BITS'(pos_reg) < count_reg;

    okvt_store u_store (
        .aclk    (aclk),
        .req     (req),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            ov_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            cmp_valid_reg <= cmp_valid_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg <= cmp_idx_next;
        ok_reg      <= ok_next;
        full_reg    <= full_next;
        kout_reg    <= kout_next;
        vout_reg    <= vout_next;
        fpos_reg    <= fpos_next;
        ocnt_reg    <= ocnt_next;
        if (accept) begin
            op_reg  <= in_op;
            key_reg <= s_axis_tdata[33:2];
            val_reg <= s_axis_tdata[65:34];
            ins_reg <= s_axis_tdata[66];
            upd_reg <= s_axis_tdata[67];
            pos_reg <= in_pos;
        end
    end

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        ov_next        = ov_reg && !m_axis_tready;
        ok_next        = ok_reg;
        full_next      = full_reg;
        kout_next      = kout_reg;
        vout_next      = vout_reg;
        fpos_next      = fpos_reg;
        ocnt_next      = ocnt_reg;
        s_axis_tready  = 1'b0;
        req.wr_en      = 1'b0;
        req.wr_addr    = cmp_idx_reg;
        req.wr_data    = '{value: val_reg, key: key_reg};
        req.rd_en      = 1'b0;
        req.rd_addr    = idx_reg[ADDR_BITS-1:0];

        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                req.rd_addr   = ADDR_BITS'(in_pos);
                if (s_axis_tvalid) begin
                    req.rd_en      = 1'b1;
                    idx_next       = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = (in_op == OP_READ) ? ST_RDOUT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (hit && op_reg == OP_ERASE) begin
                    idx_next       = CNT_BITS'(cmp_idx_reg) + CNT_BITS'(1);
                    cmp_valid_next = 1'b0;
                    state_next     = ST_SHIFT;
                end else if (hit || idx_reg >= count_reg) begin
                    if (out_free) begin
                        ov_next    = 1'b1;
                        ok_next    = 1'b0;
                        full_next  = 1'b0;
                        kout_next  = '0;
                        vout_next  = '0;
                        fpos_next  = '0;
                        ocnt_next  = count_reg;
                        state_next = ST_IDLE;
                        unique case (op_reg)
                            OP_WRITE: begin
                                if (hit) begin
                                    if (upd_reg) begin
                                        req.wr_en = 1'b1;
                                        ok_next   = 1'b1;
                                    end
                                end else if (ins_reg) begin
                                    if (count_reg < CNT_BITS'(CAPACITY)) begin
                                        req.wr_en   = 1'b1;
                                        req.wr_addr = count_reg[ADDR_BITS-1:0];
                                        count_next  = count_reg + CNT_BITS'(1);
                                        ocnt_next   = count_reg + CNT_BITS'(1);
                                        ok_next     = 1'b1;
                                    end else begin
                                        full_next = 1'b1;
                                    end
                                end
                            end
                            OP_LOOKUP: begin
                                if (hit) begin
                                    ok_next   = 1'b1;
                                    vout_next = rd_data.value;
                                    fpos_next = cmp_idx_reg;
                                end
                            end
                            OP_ERASE: begin
                            end
                            OP_READ: begin
                            end
                        endcase
                    end
                end else begin
                    req.rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[ADDR_BITS-1:0];
                    idx_next       = idx_reg + CNT_BITS'(1);
                end
            end
            ST_SHIFT: begin
                // move entry cmp_idx down one place while reading the next
                req.wr_en   = cmp_valid_reg;
                req.wr_addr = cmp_idx_reg - ADDR_BITS'(1);
                req.wr_data = rd_data;
                if (idx_reg < count_reg) begin
                    req.rd_en      = 1'b1;
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = idx_reg[ADDR_BITS-1:0];
                    idx_next       = idx_reg + CNT_BITS'(1);
                end else if (out_free) begin
                    count_next     = count_reg - CNT_BITS'(1);
                    cmp_valid_next = 1'b0;
                    ov_next        = 1'b1;
                    ok_next        = 1'b1;
                    full_next      = 1'b0;
                    kout_next      = '0;
                    vout_next      = '0;
                    fpos_next      = '0;
                    ocnt_next      = count_reg - CNT_BITS'(1);
                    state_next     = ST_IDLE;
                end
            end
            ST_RDOUT: begin
                if (out_free) begin
                    ov_next    = 1'b1;
                    ok_next    = pos_ok;
                    full_next  = 1'b0;
                    kout_next  = pos_ok ? rd_data.key : '0;
                    vout_next  = pos_ok ? rd_data.value : '0;
                    fpos_next  = '0;
                    ocnt_next  = count_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {1'b0, ocnt_reg, fpos_reg, vout_reg, kout_reg, full_reg, ok_reg};

    assign count_step_ok = (count_next == count_reg)
                           || (count_next == count_reg + CNT_BITS'(1))
                           || (count_next == count_reg - CNT_BITS'(1));
    assign count_grow_ok = (count_next != count_reg + CNT_BITS'(1))
                           || (ov_next && ok_next && ocnt_next == count_next);
    assign shift_wr_ok   = !(state_reg == ST_SHIFT && req.wr_en)
                           || (CNT_BITS'(req.wr_addr) + CNT_BITS'(1) < count_reg);

    `OKVT_ASSERT(a_count_cap, aclk, aresetn, count_reg <= CNT_BITS'(CAPACITY), "count too large")
    `OKVT_ASSERT(a_count_step, aclk, aresetn, count_step_ok, "count jumped")
    `OKVT_ASSERT(a_grow_ok, aclk, aresetn, count_grow_ok, "count grew without ok result")
    `OKVT_ASSERT(a_shift_addr, aclk, aresetn, shift_wr_ok, "compaction write beyond entries")
    `OKVT_ASSERT(a_full_not_ok, aclk, aresetn, ov_reg |-> !(ok_reg && full_reg), "full and ok")

endmodule

`default_nettype wire
